>>> hdl/sawlc_pkg.sv
// sawlc_pkg: shared types and constants of the set-associative write-back cache
// holds result kinds, register indexes, request opcodes, field widths and the divider request and response types
// no dependencies
package sawlc_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 32;
    localparam int TAG_W  = 16;
    localparam int RANK_W = 8;
    localparam int OFF_W  = 5;
    localparam int SET_W  = 9;

    // result kinds
    localparam logic [1:0] KIND_RESP = 2'd0;
    localparam logic [1:0] KIND_WB   = 2'd1;
    localparam logic [1:0] KIND_FREQ = 2'd2;
    localparam logic [1:0] KIND_REJ  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_BLOCK_WORDS = 2'd0;
    localparam logic [1:0] REG_NUM_SETS    = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;

    // request opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] dividend;
        logic [SET_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quot;
        logic [SET_W-1:0]  rem;
    } div_rsp_t;

endpackage

>>> hdl/sawlc_div.sv
// sawlc_div: shared restoring divider, one quotient bit per cycle
// 16-bit dividend by 9-bit divisor, done pulses for a single cycle, registered together with the last step
// depends on sawlc_pkg
module sawlc_div
    import sawlc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t div_req,
    output div_rsp_t div_rsp
);

    localparam int CNT_W = $clog2(ADDR_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] quot_reg;
    logic [SET_W-1:0]  rem_reg;
    logic [SET_W-1:0]  dvsr_reg;
    logic [SET_W:0]    trial;
    logic              fits;

    // trial subtraction of one step
    assign trial = {rem_reg, quot_reg[ADDR_W-1]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quot_reg <= div_req.dividend;
                rem_reg  <= '0;
                dvsr_reg <= div_req.divisor;
            end else if (busy_reg) begin
                rem_reg  <= fits ? SET_W'(trial - {1'b0, dvsr_reg}) : trial[SET_W-1:0];
                quot_reg <= {quot_reg[ADDR_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ADDR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign div_rsp.done = done_reg;
    assign div_rsp.quot = quot_reg;
    assign div_rsp.rem  = rem_reg;

endmodule

>>> hdl/set_assoc_writeback_lru_cache_top.sv
// set_assoc_writeback_lru_cache_top: write-back, write-allocate word cache with LRU ranks
// sequencer, tag/rank/word memories and line status bits; uses sawlc_div for address split
// depends on sawlc_pkg and sawlc_div
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tdata {fill_word, store_word, address}, tuser {is_write, opcode}
// m_       out  m_tvalid/m_tready  tdata {word, mem_address}, tuser {was_hit, kind}, tlast = last
// cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// a processor miss runs through the accept, two divisions in the shared divider, a scan of the
// set with a tag read and compare per way, the victim choice and a rank read and write per way,
// then the tag update and the fill request; a dirty victim adds the write-back of its block
// words, a hit stops the scan at its way and ends with the rank update, the word access and
// the response, a rejected request goes straight to its result; each fill word is taken in
// idle, the last one then completes the pending access. reset is synchronous; the block takes
// one request at a time and holds in any output state until m_tready frees the output register.
module set_assoc_writeback_lru_cache_top
    import sawlc_pkg::*;
#(
    parameter int LINES           = 256,
    parameter int MAX_BLOCK_WORDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // address[15:0], store_word[47:16], fill_word[79:48]
    input  logic [1:0]  s_tuser,   // opcode[0], is_write[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mem_address[15:0], word[47:16]
    output logic [2:0]  m_tuser,   // kind[1:0], was_hit[2]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata
);

    localparam int LW  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WDEPTH = LINES * MAX_BLOCK_WORDS;
    localparam int WIW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam logic [WIW-1:0] MBW_W   = WIW'(MAX_BLOCK_WORDS);
    localparam logic [6:0]     MBW_C   = 7'(MAX_BLOCK_WORDS);
    localparam logic [17:0]    LINES_C = 18'(LINES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_REJ   = 5'd1;
    localparam logic [4:0] S_DIV1  = 5'd2;
    localparam logic [4:0] S_DIV2  = 5'd3;
    localparam logic [4:0] S_SRD   = 5'd4;
    localparam logic [4:0] S_SEV   = 5'd5;
    localparam logic [4:0] S_VIC   = 5'd6;
    localparam logic [4:0] S_TRD   = 5'd7;
    localparam logic [4:0] S_TEV   = 5'd8;
    localparam logic [4:0] S_HIT   = 5'd9;
    localparam logic [4:0] S_HRESP = 5'd10;
    localparam logic [4:0] S_WRD   = 5'd11;
    localparam logic [4:0] S_WEM   = 5'd12;
    localparam logic [4:0] S_MUPD  = 5'd13;
    localparam logic [4:0] S_FREQ  = 5'd14;
    localparam logic [4:0] S_FDONE = 5'd15;
    localparam logic [4:0] S_FRESP = 5'd16;

    function automatic logic [WIW-1:0] word_idx(input logic [LW-1:0] line,
                                                input logic [OFF_W-1:0] off);
        word_idx = WIW'(line) * MBW_W + WIW'(off);
    endfunction

    // request fields
    logic              s_op;
    logic              s_wr;
    logic [ADDR_W-1:0] s_addr;
    logic [DATA_W-1:0] s_sdata;
    logic [DATA_W-1:0] s_fdata;
    logic              s_acc;

    assign s_op    = s_tuser[0];
    assign s_wr    = s_tuser[1];
    assign s_addr  = s_tdata[15:0];
    assign s_sdata = s_tdata[47:16];
    assign s_fdata = s_tdata[79:48];
    assign s_acc   = s_tvalid && s_tready;

    logic [4:0]        state_reg;
    logic [OFF_W-1:0]  bw_reg;
    logic [SET_W-1:0]  ns_reg;
    logic [SET_W-1:0]  ways_reg;
    logic [LINES-1:0]  valid_reg;
    logic [LINES-1:0]  dirty_reg;
    logic [LINES-1:0]  known_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic              wr_reg;
    logic [DATA_W-1:0] sdata_reg;
    logic [ADDR_W-1:0] rej_addr_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SET_W-1:0]  base_reg;
    logic [ADDR_W-1:0] setbw_reg;
    logic [13:0]       bwns_reg;
    logic [SET_W-1:0]  w_reg;
    logic              inv_found_reg;
    logic [LW-1:0]     inv_line_reg;
    logic [RANK_W-1:0] inv_rank_reg;
    logic [LW-1:0]     max_line_reg;
    logic [RANK_W-1:0] max_rank_reg;
    logic [TAG_W-1:0]  max_tag_reg;
    logic [LW-1:0]     sel_line_reg;
    logic [RANK_W-1:0] sel_rank_reg;
    logic              hit_reg;
    logic              wb_reg;
    logic [ADDR_W-1:0] vbase_reg;
    logic [OFF_W-1:0]  j_reg;

    logic              miss_pending_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_store_reg;
    logic [DATA_W-1:0] pend_data_reg;
    logic [OFF_W-1:0]  pend_off_reg;
    logic [OFF_W-1:0]  fill_cnt_reg;
    logic [LW-1:0]     victim_reg;

    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;
    logic [2:0]        m_tuser_reg;
    logic              m_tlast_reg;

    // memories and their read registers
    logic [TAG_W-1:0]  tag_mem  [LINES];
    logic [RANK_W-1:0] rank_mem [LINES];
    logic [DATA_W-1:0] word_mem [WDEPTH];
    logic [TAG_W-1:0]  tag_q;
    logic [RANK_W-1:0] rank_q;
    logic [DATA_W-1:0] word_q;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sawlc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // geometry check
    logic cfg_bad;
    assign cfg_bad = (bw_reg == '0) || (ns_reg == '0) || (ways_reg == '0) ||
                     (7'(bw_reg) > MBW_C) || (18'(ns_reg * ways_reg) > LINES_C);

    // scan position
    logic [SET_W-1:0]  line_sum;
    logic [LW-1:0]     cur_line;
    logic              last_way;
    logic              cur_valid;
    logic [RANK_W-1:0] eff_rank;
    logic [RANK_W-1:0] new_rank;
    logic              hit_now;

    assign line_sum  = base_reg + w_reg;
    assign cur_line  = LW'(line_sum);
    assign last_way  = (10'(w_reg) + 10'd1) == 10'(ways_reg);
    assign cur_valid = valid_reg[cur_line];
    assign eff_rank  = known_reg[cur_line] ? rank_q : w_reg[RANK_W-1:0];
    assign hit_now   = cur_valid && (tag_q == tag_reg);
    assign new_rank  = (cur_line == sel_line_reg) ? '0 :
                       (eff_rank < sel_rank_reg) ? eff_rank + 1'b1 : eff_rank;

    assign s_tready = (state_reg == S_IDLE);

    // divider requests: word address by block size, then line number by set count
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = s_addr;
        div_req.divisor  = SET_W'(bw_reg);
        if (state_reg == S_DIV1) begin
            div_req.start    = div_rsp.done;
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = ns_reg;
        end else if (state_reg == S_IDLE) begin
            div_req.start = s_acc && (s_op == OP_ACCESS) && !cfg_bad && !miss_pending_reg;
        end
    end

    // word memory port control
    logic           word_we;
    logic           word_re;
    logic [WIW-1:0] word_addr;
    logic [DATA_W-1:0] word_wdata;

    always_comb begin
        word_we    = 1'b0;
        word_re    = 1'b0;
        word_addr  = word_idx(sel_line_reg, j_reg);
        word_wdata = sdata_reg;
        unique case (state_reg)
            S_IDLE: begin
                word_we    = s_acc && (s_op == OP_FILL) && miss_pending_reg;
                word_addr  = word_idx(victim_reg, fill_cnt_reg);
                word_wdata = s_fdata;
            end
            S_HIT: begin
                word_addr = word_idx(sel_line_reg, off_reg);
                word_we   = wr_reg;
                word_re   = !wr_reg;
            end
            S_WRD: begin
                word_re = 1'b1;
            end
            S_FDONE: begin
                word_addr  = word_idx(victim_reg, pend_off_reg);
                word_we    = pend_store_reg;
                word_re    = !pend_store_reg;
                word_wdata = pend_data_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (word_we) word_mem[word_addr] <= word_wdata;
        if (word_re) word_q <= word_mem[word_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_MUPD) tag_mem[sel_line_reg] <= tag_reg;
        if (state_reg == S_SRD) tag_q <= tag_mem[cur_line];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_TEV) rank_mem[cur_line] <= new_rank;
        if (state_reg == S_SRD || state_reg == S_TRD) rank_q <= rank_mem[cur_line];
    end

    // result selection
    logic              slot_free;
    logic              emit;
    logic [1:0]        e_kind;
    logic [ADDR_W-1:0] e_addr;
    logic [DATA_W-1:0] e_word;
    logic              e_hit;
    logic              e_last;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        emit   = 1'b0;
        e_kind = KIND_REJ;
        e_addr = rej_addr_reg;
        e_word = '0;
        e_hit  = 1'b0;
        e_last = 1'b1;
        unique case (state_reg)
            S_REJ: emit = slot_free;
            S_HRESP: begin
                emit   = slot_free;
                e_kind = KIND_RESP;
                e_addr = addr_reg;
                e_word = wr_reg ? sdata_reg : word_q;
                e_hit  = 1'b1;
            end
            S_WEM: begin
                emit   = slot_free;
                e_kind = KIND_WB;
                e_addr = vbase_reg + ADDR_W'(j_reg);
                e_word = word_q;
                e_last = 1'b0;
            end
            S_FREQ: begin
                emit   = slot_free;
                e_kind = KIND_FREQ;
                e_addr = addr_reg - ADDR_W'(off_reg);
            end
            S_FRESP: begin
                emit   = slot_free;
                e_kind = KIND_RESP;
                e_addr = pend_addr_reg;
                e_word = pend_store_reg ? pend_data_reg : word_q;
            end
            default: begin
            end
        endcase
    end

    // sequencer, line status and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            bw_reg           <= OFF_W'(1);
            ns_reg           <= SET_W'(1);
            ways_reg         <= SET_W'(1);
            valid_reg        <= '0;
            dirty_reg        <= '0;
            known_reg        <= '0;
            miss_pending_reg <= 1'b0;
            fill_cnt_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            // output register
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {e_word, e_addr};
                m_tuser_reg  <= {e_hit, e_kind};
                m_tlast_reg  <= e_last;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        addr_reg  <= s_addr;
                        wr_reg    <= s_wr;
                        sdata_reg <= s_sdata;
                        if (s_op == OP_FILL) begin
                            if (!miss_pending_reg) begin
                                rej_addr_reg <= '0;
                                state_reg    <= S_REJ;
                            end else begin
                                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                                if ((6'(fill_cnt_reg) + 6'd1) >= 6'(bw_reg))
                                    state_reg <= S_FDONE;
                            end
                        end else if (cfg_bad || miss_pending_reg) begin
                            rej_addr_reg <= s_addr;
                            state_reg    <= S_REJ;
                        end else begin
                            state_reg <= S_DIV1;
                        end
                    end
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        off_reg   <= div_rsp.rem[OFF_W-1:0];
                        bwns_reg  <= 14'(bw_reg) * 14'(ns_reg);
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        tag_reg       <= div_rsp.quot;
                        base_reg      <= SET_W'(div_rsp.rem * ways_reg);
                        setbw_reg     <= ADDR_W'(div_rsp.rem * bw_reg);
                        w_reg         <= '0;
                        inv_found_reg <= 1'b0;
                        state_reg     <= S_SRD;
                    end
                end
                S_SRD: state_reg <= S_SEV;
                S_SEV: begin
                    if (hit_now) begin
                        sel_line_reg <= cur_line;
                        sel_rank_reg <= eff_rank;
                        hit_reg      <= 1'b1;
                        w_reg        <= '0;
                        state_reg    <= S_TRD;
                    end else begin
                        if (!cur_valid && !inv_found_reg) begin
                            inv_found_reg <= 1'b1;
                            inv_line_reg  <= cur_line;
                            inv_rank_reg  <= eff_rank;
                        end
                        if (w_reg == '0 || eff_rank > max_rank_reg) begin
                            max_line_reg <= cur_line;
                            max_rank_reg <= eff_rank;
                            max_tag_reg  <= tag_q;
                        end
                        if (last_way) begin
                            state_reg <= S_VIC;
                        end else begin
                            w_reg     <= w_reg + 1'b1;
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_VIC: begin
                    hit_reg      <= 1'b0;
                    sel_line_reg <= inv_found_reg ? inv_line_reg : max_line_reg;
                    sel_rank_reg <= inv_found_reg ? inv_rank_reg : max_rank_reg;
                    wb_reg       <= !inv_found_reg && dirty_reg[max_line_reg];
                    vbase_reg    <= ADDR_W'(max_tag_reg * bwns_reg) + setbw_reg;
                    w_reg        <= '0;
                    state_reg    <= S_TRD;
                end
                S_TRD: state_reg <= S_TEV;
                S_TEV: begin
                    known_reg[cur_line] <= 1'b1;
                    if (last_way) begin
                        j_reg <= '0;
                        if (hit_reg)     state_reg <= S_HIT;
                        else if (wb_reg) state_reg <= S_WRD;
                        else             state_reg <= S_MUPD;
                    end else begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= S_TRD;
                    end
                end
                S_HIT: begin
                    if (wr_reg) dirty_reg[sel_line_reg] <= 1'b1;
                    state_reg <= S_HRESP;
                end
                S_WRD: state_reg <= S_WEM;
                S_WEM: begin
                    if (slot_free) begin
                        j_reg <= j_reg + 1'b1;
                        if ((6'(j_reg) + 6'd1) == 6'(bw_reg)) state_reg <= S_MUPD;
                        else                                  state_reg <= S_WRD;
                    end
                end
                S_MUPD: begin
                    valid_reg[sel_line_reg] <= 1'b1;
                    dirty_reg[sel_line_reg] <= 1'b0;
                    miss_pending_reg        <= 1'b1;
                    pend_addr_reg           <= addr_reg;
                    pend_store_reg          <= wr_reg;
                    pend_data_reg           <= sdata_reg;
                    pend_off_reg            <= off_reg;
                    fill_cnt_reg            <= '0;
                    victim_reg              <= sel_line_reg;
                    state_reg               <= S_FREQ;
                end
                S_FDONE: begin
                    if (pend_store_reg) dirty_reg[victim_reg] <= 1'b1;
                    miss_pending_reg <= 1'b0;
                    fill_cnt_reg     <= '0;
                    state_reg        <= S_FRESP;
                end
                S_HRESP, S_FREQ, S_FRESP, S_REJ: begin
                    if (slot_free) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            // a write to any of the three configuration registers drops all lines and any pending miss
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_BLOCK_WORDS: bw_reg   <= cfg_wdata[OFF_W-1:0];
                    REG_NUM_SETS:    ns_reg   <= cfg_wdata;
                    REG_WAYS:        ways_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
                if (cfg_index == REG_BLOCK_WORDS || cfg_index == REG_NUM_SETS ||
                    cfg_index == REG_WAYS) begin
                    valid_reg        <= '0;
                    dirty_reg        <= '0;
                    known_reg        <= '0;
                    miss_pending_reg <= 1'b0;
                    fill_cnt_reg     <= '0;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // a pending miss only exists under a valid geometry
    a_pend_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        miss_pending_reg |-> !cfg_bad)
        else $error("miss pending with bad geometry");

    // fill counter stays inside the block while a miss waits for fill words
    a_fill_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (miss_pending_reg && (state_reg != S_FDONE)) |-> (fill_cnt_reg < bw_reg))
        else $error("fill count past block size");

    // way counter stays inside the set during scan and rank update
    a_way_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEV || state_reg == S_TEV) |-> (w_reg < ways_reg))
        else $error("way counter out of range");

    // first division always leads to the second
    a_div_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV1) |=> (state_reg == S_DIV1 || state_reg == S_DIV2))
        else $error("divide sequence broken");

endmodule

>>> dv/set_assoc_writeback_lru_cache_top_tb.sv
// set_assoc_writeback_lru_cache_top_tb: self-checking bench for the write-back lru word cache
// runs a directed table and random phases over several geometries against an internal predictor
// depends on sawlc_pkg and set_assoc_writeback_lru_cache_top
module set_assoc_writeback_lru_cache_top_tb;
    import sawlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINES   = 256;
    localparam int MAXBW    = 16;
    localparam int WD_LIMIT = 40000;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [31:0] word;
        logic        hit;
        logic        last;
    } cache_rsp_t;

    typedef struct {
        logic        op;
        logic [15:0] addr;
        logic        wr;
        logic [31:0] sdata;
        logic [31:0] fdata;
        bit          typed;
        logic [1:0]  ekind;
        logic [15:0] eaddr;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // address[15:0], store_word[47:16], fill_word[79:48]
    logic [1:0]  s_tuser;   // opcode[0], is_write[1]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // mem_address[15:0], word[47:16]
    logic [2:0]  m_tuser;   // kind[1:0], was_hit[2]
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_wdata;

    set_assoc_writeback_lru_cache_top dut (.*);

    // shadow cache state
    logic [15:0] sh_tag [NLINES];
    bit          sh_vld [NLINES];
    bit          sh_drt [NLINES];
    logic [7:0]  sh_rank [NLINES];
    logic [31:0] sh_word [NLINES*MAXBW];
    int unsigned sh_bw, sh_ns, sh_ways;
    bit          miss_open;
    logic [15:0] miss_addr;
    bit          miss_store;
    logic [31:0] miss_data;
    int unsigned fills_seen;
    int unsigned victim;

    cache_rsp_t  rsp_q[$];
    int          errors;
    int          snd_idle, rcv_idle;
    int          quiet_cycles;

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < NLINES; i++) begin
            sh_vld[i]  = 0;
            sh_drt[i]  = 0;
            sh_rank[i] = sh_ways ? 8'(i % sh_ways) : 8'd0;
        end
        miss_open  = 0;
        fills_seen = 0;
    endfunction

    function automatic bit geometry_bad();
        return sh_bw == 0 || sh_ns == 0 || sh_ways == 0 || sh_bw > MAXBW ||
               sh_ns * sh_ways > NLINES;
    endfunction

    function automatic int unsigned widx(int unsigned line, int unsigned off);
        int unsigned idx;
        idx = line * MAXBW + off;
        return idx < NLINES * MAXBW ? idx : 0;
    endfunction

    function automatic void push_rsp(logic [1:0] k, logic [31:0] a, logic [31:0] w,
                                     logic h, logic l);
        cache_rsp_t r;
        r.kind = k;
        r.addr = a[15:0];
        r.word = w;
        r.hit  = h;
        r.last = l;
        rsp_q.push_back(r);
    endfunction

    function automatic void make_mru(int unsigned base, int unsigned way);
        logic [7:0] r;
        r = sh_rank[base + way];
        for (int unsigned i = 0; i < sh_ways; i++)
            if (sh_rank[base + i] < r) sh_rank[base + i]++;
        sh_rank[base + way] = 0;
    endfunction

    // predicts the results of one accepted request
    function automatic void cache_predict(logic op, logic [15:0] addr, logic wr,
                                          logic [31:0] sdata, logic [31:0] fdata);
        int unsigned off, set, tg, base, w, line, j, vbase;
        if (op == OP_FILL) begin
            if (!miss_open) begin
                push_rsp(KIND_REJ, 0, 0, 0, 1);
                return;
            end
            sh_word[widx(victim, fills_seen)] = fdata;
            fills_seen++;
            if (fills_seen < sh_bw) return;
            off = miss_addr % sh_bw;
            j = widx(victim, off);
            if (miss_store) begin
                sh_word[j] = miss_data;
                sh_drt[victim] = 1;
            end
            miss_open  = 0;
            fills_seen = 0;
            push_rsp(KIND_RESP, miss_addr, sh_word[j], 0, 1);
            return;
        end
        if (geometry_bad() || miss_open) begin
            push_rsp(KIND_REJ, addr, 0, 0, 1);
            return;
        end
        off  = addr % sh_bw;
        set  = (addr / sh_bw) % sh_ns;
        tg   = addr / (sh_bw * sh_ns);
        base = set * sh_ways;
        // hit search
        for (w = 0; w < sh_ways; w++) begin
            line = base + w;
            if (sh_vld[line] && sh_tag[line] == 16'(tg)) begin
                make_mru(base, w);
                j = widx(line, off);
                if (wr) begin
                    sh_word[j] = sdata;
                    sh_drt[line] = 1;
                end
                push_rsp(KIND_RESP, addr, sh_word[j], 1, 1);
                return;
            end
        end
        // victim choice: first invalid, else oldest
        for (w = 0; w < sh_ways; w++)
            if (!sh_vld[base + w]) break;
        if (w == sh_ways) begin
            w = 0;
            for (j = 1; j < sh_ways; j++)
                if (sh_rank[base + j] > sh_rank[base + w]) w = j;
        end
        line = base + w;
        if (sh_vld[line] && sh_drt[line]) begin
            vbase = sh_tag[line] * sh_bw * sh_ns + set * sh_bw;
            for (j = 0; j < sh_bw; j++)
                push_rsp(KIND_WB, vbase + j, sh_word[widx(line, j)], 0, 0);
        end
        sh_tag[line] = 16'(tg);
        sh_vld[line] = 1;
        sh_drt[line] = 0;
        make_mru(base, w);
        miss_open  = 1;
        miss_addr  = addr;
        miss_store = wr;
        miss_data  = sdata;
        fills_seen = 0;
        victim     = line & 8'hFF;
        push_rsp(KIND_FREQ, addr - off, 0, 0, 1);
    endfunction

    // drive one request and wait for it to be taken
    task automatic send_req(logic op, logic [15:0] addr, logic wr, logic [31:0] sdata,
                            logic [31:0] fdata);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fdata, sdata, addr};
        s_tuser  <= {wr, op};
        do @(posedge aclk); while (!s_tready);
        cache_predict(op, addr, wr, sdata, fdata);
    endtask

    // idle the sender and wait until every result has come
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (rsp_q.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        drain();
        repeat (60) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BLOCK_WORDS) sh_bw = val[4:0];
        else if (idx == REG_NUM_SETS) sh_ns = val;
        else sh_ways = val;
        clear_shadow();
    endtask

    // one random request, mostly well-formed miss/fill sequences
    task automatic random_req();
        logic [15:0] a;
        int unsigned span;
        if (miss_open && $urandom_range(99) < 92) begin
            send_req(OP_FILL, 16'($urandom), 1'($urandom), $urandom, $urandom);
            return;
        end
        if ($urandom_range(99) < 4) begin
            send_req(OP_FILL, 16'($urandom), 1'($urandom), $urandom, $urandom);
            return;
        end
        if (geometry_bad() || $urandom_range(99) < 10) begin
            a = 16'($urandom);
        end else begin
            span = sh_bw * sh_ns;
            a = 16'($urandom_range(sh_ways + 1) * span + $urandom_range(span - 1));
        end
        send_req(OP_ACCESS, a, 1'($urandom), $urandom, $urandom);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        cache_rsp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
            if (m_tvalid && m_tready) begin
                if (rsp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result kind=%0d addr=%h word=%h",
                                 m_tuser[1:0], m_tdata[15:0], m_tdata[47:16]);
                end else begin
                    e = rsp_q.pop_front();
                    if (m_tuser[1:0] !== e.kind || m_tdata[15:0] !== e.addr ||
                        m_tdata[47:16] !== e.word || m_tuser[2] !== e.hit ||
                        m_tlast !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display(
                                "mismatch exp k=%0d a=%h w=%h h=%0d l=%0d got %0d %h %h %0d %0d",
                                e.kind, e.addr, e.word, e.hit, e.last, m_tuser[1:0],
                                m_tdata[15:0], m_tdata[47:16], m_tuser[2], m_tlast);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("set_assoc_writeback_lru_cache_top_tb: done, errors");
            $finish;
        end
    end

    // directed table, reset geometry 1x1x1
    dir_row_t dir_tbl[] = '{
        '{OP_FILL,   16'h0000, 0, 32'h0,        32'h1234_5678, 1, KIND_REJ,  16'h0000},
        '{OP_ACCESS, 16'h0000, 0, 32'h0,        32'h0,         1, KIND_FREQ, 16'h0000},
        '{OP_ACCESS, 16'h0005, 0, 32'h0,        32'h0,         1, KIND_REJ,  16'h0005},
        '{OP_FILL,   16'hFFFF, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, KIND_RESP, 16'h0000},
        '{OP_ACCESS, 16'h0000, 1, 32'h8000_0000, 32'h0,        0, KIND_RESP, 16'h0000},
        '{OP_ACCESS, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, KIND_RESP, 16'h0000},
        '{OP_FILL,   16'h0000, 0, 32'h0,        32'h0000_0000, 0, KIND_RESP, 16'h0000},
        '{OP_ACCESS, 16'hFFFF, 0, 32'h0,        32'h0,         0, KIND_RESP, 16'h0000},
        '{OP_ACCESS, 16'h0000, 0, 32'h0,        32'h0,         0, KIND_RESP, 16'h0000},
        '{OP_FILL,   16'h0000, 0, 32'h0,        32'hFFFF_FFFF, 0, KIND_RESP, 16'h0000},
        '{OP_ACCESS, 16'h0000, 1, 32'h5A5A_A5A5, 32'h0,        0, KIND_RESP, 16'h0000},
        '{OP_ACCESS, 16'h0001, 1, 32'h0,        32'h0,         0, KIND_RESP, 16'h0000},
        '{OP_FILL,   16'h0000, 0, 32'h0,        32'h0F0F_0F0F, 0, KIND_RESP, 16'h0000}
    };

    // geometry phases: block words, sets, ways, requests
    int ph_bw[]  = '{4, 16, 3, 1,   16,  17, 4,  1, 0, 5, 2};
    int ph_ns[]  = '{4, 16, 5, 256, 1,   1,  16, 0, 1, 2, 8};
    int ph_wy[]  = '{2, 16, 7, 1,   256, 1,  32, 1, 1, 8, 32};
    int ph_cnt[] = '{40, 50, 40, 30, 12, 3,  3,  3, 3, 40, 40};

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_BLOCK_WORDS;
        cfg_wdata = '0;
        errors    = 0;
        snd_idle  = 14;
        rcv_idle  = 46;
        sh_bw = 1; sh_ns = 1; sh_ways = 1;
        for (int i = 0; i < NLINES * MAXBW; i++) sh_word[i] = '0;
        for (int i = 0; i < NLINES; i++) sh_tag[i] = '0;
        clear_shadow();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i]) begin
            send_req(dir_tbl[i].op, dir_tbl[i].addr, dir_tbl[i].wr, dir_tbl[i].sdata,
                     dir_tbl[i].fdata);
            if (dir_tbl[i].typed && (rsp_q[$].kind !== dir_tbl[i].ekind ||
                                     rsp_q[$].addr !== dir_tbl[i].eaddr)) begin
                errors++;
                if (errors <= 10) $display("directed row %0d predicted wrong result", i);
            end
        end

        foreach (ph_bw[p]) begin
            if (p == 4) begin
                snd_idle = 46;
                rcv_idle = 14;
            end else if (p == 8) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_reg(REG_BLOCK_WORDS, 9'(ph_bw[p]));
            write_reg(REG_NUM_SETS, 9'(ph_ns[p]));
            write_reg(REG_WAYS, 9'(ph_wy[p]));
            for (int k = 0; k < ph_cnt[p]; k++) begin
                // hold off until the cache has answered everything
                if (k == ph_cnt[p] / 2) drain();
                random_req();
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("set_assoc_writeback_lru_cache_top_tb: done, clean");
        else
            $display("set_assoc_writeback_lru_cache_top_tb: done, errors");
        $finish;
    end

endmodule
